// ===== design/fan_curve_duty_controller_core_macros.svh =====
// Assertion macros shared by the fan curve controller checkers.
// Depends on nothing; included by the checker file.
`ifndef FAN_CURVE_DUTY_CONTROLLER_CORE_MACROS_SVH
`define FAN_CURVE_DUTY_CONTROLLER_CORE_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define FCDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also covers the reset cycles
`define FCDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== design/fcdc_pkg.sv =====
// Package for the fan curve duty controller: payload types, state codes,
// sizes and arithmetic helpers. Depends on nothing.
package fcdc_pkg;

   // Curve table size
   localparam int CURVE_POINTS = 16;
   localparam int IDX_W        = $clog2(CURVE_POINTS);

   // Percent limits for a duty write
   localparam logic [6:0] PCT_MIN = 7'd10;
   localparam logic [6:0] PCT_MAX = 7'd100;

   // floor(x/100) as (x*PWM_RECIP) >> PWM_SHIFT, exact for x up to 25500
   localparam int PWM_RECIP = 5243;
   localparam int PWM_SHIFT = 19;

   typedef struct packed {
      logic       command;
      logic [7:0] temperature;
      logic [7:0] duty_raw;
      logic [3:0] point_index;
      logic [7:0] point_temp;
      logic [6:0] point_duty;
   } req_payload_type;

   typedef struct packed {
      logic       write_valid;
      logic [7:0] pwm_byte;
      logic [6:0] target_percent;
   } rsp_payload_type;

   // One curve point as stored in the table
   typedef struct packed {
      logic [7:0] temp;
      logic [6:0] duty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_CONV    = 7'b0000010,
      ST_DOWN    = 7'b0000100,
      ST_UPPRIME = 7'b0001000,
      ST_UP      = 7'b0010000,
      ST_DECIDE  = 7'b0100000,
      ST_SCALE   = 7'b1000000
   } state_type;

   // Response pending is its own code outside the scan states
   typedef enum logic [1:0] {
      OUT_EMPTY = 2'b01,
      OUT_FULL  = 2'b10
   } out_state_type;

   // floor(raw*100/255) via x/255 = (x + (x>>8) + 1) >> 8 for x < 65535
   function automatic logic [6:0] cur_percent(input logic [7:0] raw);
      logic [14:0] prod;
      logic [15:0] sum;
      prod = 15'(raw) * 15'd100;
      sum  = 16'(prod) + 16'(prod >> 8) + 16'd1;
      return sum[14:8];
   endfunction

   // Limit a percent to the writable range
   function automatic logic [6:0] clamp_percent(input logic [6:0] pct);
      logic [6:0] res;
      res = pct;
      if (pct < PCT_MIN) res = PCT_MIN;
      if (pct > PCT_MAX) res = PCT_MAX;
      return res;
   endfunction

   // floor(prod/100) for prod = pct*255
   function automatic logic [7:0] pwm_from_product(input logic [14:0] prod);
      logic [27:0] wide;
      wide = 28'(prod) * 28'(PWM_RECIP);
      return wide[PWM_SHIFT+7:PWM_SHIFT];
   endfunction

endpackage

// ===== design/fcdc_if.sv =====
// Valid/ready channel interfaces for the fan curve controller.
// Depends on fcdc_pkg for the payload types.
interface fcdc_req_if;
   logic                     valid;
   logic                     ready;
   fcdc_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fcdc_rsp_if;
   logic                     valid;
   logic                     ready;
   fcdc_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/fan_curve_duty_controller_core.sv =====
// Fan curve duty controller, one fan channel, with step-down hysteresis.
// Load transaction: response valid in the cycle after acceptance.
// Sample transaction: the downward and upward scans read one curve entry a cycle
// from the table RAM; then the target is decided and, for a duty write, scaled.
// One transaction at a time; ready returns the cycle after the response is taken.
// Synchronous reset: point_count 1, last written percent 0; table undefined until loaded.
module fan_curve_duty_controller_core (
   input  logic              clock,
   input  logic              reset,
   fcdc_req_if.sink          req_chan,
   fcdc_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [4:0]        csr_write_data
);

   fcdc_pkg::state_type        state_ff, state_in;
   fcdc_pkg::out_state_type    out_ff, out_in;
   logic [fcdc_pkg::IDX_W-1:0] idx_ff, idx_in;
   fcdc_pkg::entry_type        prev_ff, prev_in;
   logic [7:0]                 temp_ff, temp_in;
   logic [7:0]                 raw_ff, raw_in;
   logic [6:0]                 cur_ff, cur_in;
   logic [6:0]                 target_ff, target_in;
   logic [6:0]                 last_pct_ff, last_pct_in;
   logic [14:0]                prod_ff, prod_in;
   logic [4:0]                 count_ff;
   fcdc_pkg::rsp_payload_type  rsp_ff, rsp_in;

   logic                       req_accept;
   logic                       ram_we;
   logic [fcdc_pkg::IDX_W-1:0] ram_waddr;
   logic [fcdc_pkg::ENTRY_W-1:0] ram_wdata;
   logic [fcdc_pkg::ENTRY_W-1:0] ram_rdata;
   fcdc_pkg::entry_type        rd_entry;
   logic [fcdc_pkg::IDX_W-1:0] last_idx;
   logic [8:0]                 mid_sum;
   logic [7:0]                 mid_temp;

   // Handshake: take a transaction only when idle and no response pending
   assign req_chan.ready = (state_ff == fcdc_pkg::ST_IDLE) && (out_ff == fcdc_pkg::OUT_EMPTY);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (out_ff == fcdc_pkg::OUT_FULL);
   assign rsp_chan.data  = rsp_ff;

   // Store curve points on load transactions inside the table
   assign ram_we    = req_accept && (req_chan.data.command == fcdc_pkg::CMD_LOAD) &&
                      (int'(req_chan.data.point_index) < fcdc_pkg::CURVE_POINTS);
   assign ram_waddr = fcdc_pkg::IDX_W'(req_chan.data.point_index);
   assign ram_wdata = {req_chan.data.point_temp, req_chan.data.point_duty};

   fcdc_ram #(
      .WIDTH (fcdc_pkg::ENTRY_W),
      .DEPTH (fcdc_pkg::CURVE_POINTS)
   ) u_table (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (idx_in),
      .read_data    (ram_rdata)
   );

   // Read data belongs to idx_ff since the address is the next index
   assign rd_entry = fcdc_pkg::entry_type'(ram_rdata);

   // Clamp the point count to the table and take the top index
   always_comb begin
      priority if (count_ff == 5'd0) begin
         last_idx = '0;
      end else if (int'(count_ff) > fcdc_pkg::CURVE_POINTS) begin
         last_idx = fcdc_pkg::IDX_W'(fcdc_pkg::CURVE_POINTS - 1);
      end else begin
         last_idx = fcdc_pkg::IDX_W'(count_ff - 5'd1);
      end
   end

   // Segment midpoint between the previous and the current entry
   assign mid_sum  = 9'(prev_ff.temp) + 9'(rd_entry.temp);
   assign mid_temp = mid_sum[8:1];

   // Sequencer: convert, scan down, scan up, decide, scale
   always_comb begin
      state_in    = state_ff;
      out_in      = out_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      temp_in     = temp_ff;
      raw_in      = raw_ff;
      cur_in      = cur_ff;
      target_in   = target_ff;
      last_pct_in = last_pct_ff;
      prod_in     = prod_ff;
      rsp_in      = rsp_ff;

      // Drop the response once taken
      if (rsp_chan.valid && rsp_chan.ready) begin
         out_in = fcdc_pkg::OUT_EMPTY;
      end

      unique case (state_ff)
         fcdc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.data.command == fcdc_pkg::CMD_LOAD) begin
                  rsp_in = '0;
                  out_in = fcdc_pkg::OUT_FULL;
               end else begin
                  temp_in  = req_chan.data.temperature;
                  raw_in   = req_chan.data.duty_raw;
                  state_in = fcdc_pkg::ST_CONV;
               end
            end
         end
         fcdc_pkg::ST_CONV: begin
            cur_in = fcdc_pkg::cur_percent(raw_ff);
            if (last_idx == '0) begin
               target_in = '0;
               state_in  = fcdc_pkg::ST_DECIDE;
            end else begin
               idx_in   = last_idx;
               state_in = fcdc_pkg::ST_DOWN;
            end
         end
         fcdc_pkg::ST_DOWN: begin
            priority if (temp_ff >= rd_entry.temp) begin
               if (rd_entry.duty > cur_ff) begin
                  target_in = rd_entry.duty;
                  state_in  = fcdc_pkg::ST_DECIDE;
               end else begin
                  idx_in   = '0;
                  state_in = fcdc_pkg::ST_UPPRIME;
               end
            end else if (idx_ff == fcdc_pkg::IDX_W'(1)) begin
               idx_in   = '0;
               state_in = fcdc_pkg::ST_UPPRIME;
            end else begin
               idx_in = idx_ff - fcdc_pkg::IDX_W'(1);
            end
         end
         fcdc_pkg::ST_UPPRIME: begin
            prev_in  = rd_entry;
            idx_in   = fcdc_pkg::IDX_W'(1);
            state_in = fcdc_pkg::ST_UP;
         end
         fcdc_pkg::ST_UP: begin
            priority if (temp_ff <= mid_temp && cur_ff > prev_ff.duty) begin
               target_in = prev_ff.duty;
               state_in  = fcdc_pkg::ST_DECIDE;
            end else if (idx_ff == last_idx) begin
               target_in = '0;
               state_in  = fcdc_pkg::ST_DECIDE;
            end else begin
               prev_in = rd_entry;
               idx_in  = idx_ff + fcdc_pkg::IDX_W'(1);
            end
         end
         fcdc_pkg::ST_DECIDE: begin
            if (target_ff != 7'd0 && target_ff != last_pct_ff) begin
               prod_in     = 15'(fcdc_pkg::clamp_percent(target_ff)) * 15'd255;
               last_pct_in = target_ff;
               state_in    = fcdc_pkg::ST_SCALE;
            end else begin
               rsp_in.write_valid    = 1'b0;
               rsp_in.pwm_byte       = '0;
               rsp_in.target_percent = target_ff;
               out_in                = fcdc_pkg::OUT_FULL;
               state_in              = fcdc_pkg::ST_IDLE;
            end
         end
         fcdc_pkg::ST_SCALE: begin
            rsp_in.write_valid    = 1'b1;
            rsp_in.pwm_byte       = fcdc_pkg::pwm_from_product(prod_ff);
            rsp_in.target_percent = target_ff;
            out_in                = fcdc_pkg::OUT_FULL;
            state_in              = fcdc_pkg::ST_IDLE;
         end
         default: begin
            state_in = fcdc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fcdc_pkg::ST_IDLE;
         out_ff      <= fcdc_pkg::OUT_EMPTY;
         last_pct_ff <= '0;
         count_ff    <= 5'd1;
      end else begin
         state_ff    <= state_in;
         out_ff      <= out_in;
         last_pct_ff <= last_pct_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      temp_ff   <= temp_in;
      raw_ff    <= raw_in;
      cur_ff    <= cur_in;
      target_ff <= target_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ===== design/fcdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fcdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== design/fcdc_checker.sv =====
// Port-level checker for the fan curve duty controller, bound to the top.
// Depends on the assertion macro header.
`include "fan_curve_duty_controller_core_macros.svh"

module fcdc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       write_valid,
   input logic [7:0] pwm_byte,
   input logic [6:0] target_percent
);

   // No new transaction while a response is pending
   `FCDC_ASSERT(a_busy_when_pending, clock, reset, rsp_valid |-> !req_ready, "ready while response pending")

   // Busy in the cycle after an accepted transaction
   `FCDC_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "ready right after accept")

   // A duty write carries a nonzero target and a byte of at least 25 (ten percent of 255, rounded down)
   `FCDC_ASSERT(a_write_fields, clock, reset, rsp_valid && write_valid |-> target_percent != 7'd0 && pwm_byte >= 8'd25, "bad duty write fields")

   // Without a write the byte stays zero
   `FCDC_ASSERT(a_no_write_byte, clock, reset, rsp_valid && !write_valid |-> pwm_byte == 8'd0, "byte set without a write")

   // Reset leaves the block idle and ready
   `FCDC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

bind fan_curve_duty_controller_core fcdc_checker u_fcdc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .write_valid    (rsp_chan.data.write_valid),
   .pwm_byte       (rsp_chan.data.pwm_byte),
   .target_percent (rsp_chan.data.target_percent)
);
